>>> rtl/core/sacl_pkg.sv
// Package for the set-associative LRU lookup block.
// Holds shared widths and the request struct passed front to back.
`default_nettype none
package sacl_pkg;
  localparam int unsigned AddrW = 32;
  localparam int unsigned OffW  = 3;
  localparam int unsigned CntW  = 32;
  localparam int unsigned WayOutW = 2;

  // request moved from the front part to the back part
  typedef struct packed {
    logic [AddrW-1:0] tag;
  } sacl_req_t;
endpackage
`default_nettype wire

>>> rtl/core/sacl_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module sacl_ram #(
  parameter int unsigned Width    = 8,
  parameter int unsigned Depth    = 16,
  parameter int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/sacl_front.sv
// Front part: takes an address, strips the block offset, queues the tag.
// Depends on sacl_pkg.
`default_nettype none
module sacl_front #(
  parameter int unsigned QDepth = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [sacl_pkg::AddrW-1:0] address_i,
  input  wire logic [sacl_pkg::OffW-1:0]  offset_bits_i,
  output logic                            full_o,
  input  wire logic                       pop_i,
  output logic                            empty_o,
  output sacl_pkg::sacl_req_t             req_o
);
  import sacl_pkg::*;
  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  sacl_req_t         q_mem [QDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // classify: offset dropped here
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_q].tag <= address_i >> offset_bits_i;
    end
  end

  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign req_o   = q_mem[rd_q];
endmodule
`default_nettype wire

>>> rtl/core/sacl_back.sv
// Back part: tag compare, LRU update, fill and statistics.
// Depends on sacl_pkg and sacl_ram (one tag RAM per way).
`default_nettype none
module sacl_back #(
  parameter int unsigned NumSets = 16,
  parameter int unsigned Ways    = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                empty_i,
  input  wire sacl_pkg::sacl_req_t req_i,
  output logic                     pop_o,
  output logic                     idle_o,
  output logic                     valid_o,
  output logic [sacl_pkg::WayOutW-1:0] way_o,
  output logic                     hit_o,
  output logic [sacl_pkg::CntW-1:0] hit_total_o,
  output logic [sacl_pkg::CntW-1:0] miss_total_o
);
  import sacl_pkg::*;
  localparam int unsigned SetW = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;

  // set = tag mod NumSets: quotient by rounded-up reciprocal, exact for
  // any 32-bit tag; the remainder only needs its low SetW bits
  localparam int unsigned RecipSh = AddrW + $clog2(NumSets);
  localparam logic [AddrW:0] RecipM =
    (AddrW+1)'(((64'd1 << RecipSh) + 64'(NumSets) - 64'd1) / 64'(NumSets));
  localparam logic [SetW-1:0] SetMul = SetW'(NumSets);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [AddrW-1:0]  tag_q;
  logic [SetW-1:0]   quo_lo_q;
  logic [SetW-1:0]   set_q;
  logic [Ways-1:0]   vld_q [NumSets];
  logic [WayW-1:0]   rank_q [NumSets][Ways];
  logic [CntW-1:0]   hits_q, miss_q;
  logic [AddrW-1:0]  rd_tag [Ways];
  logic [Ways-1:0]   we;
  logic [2*AddrW:0]  quo_prod;
  logic [SetW-1:0]   set_calc;

  // reciprocal product on the popped tag
  assign quo_prod = (2*AddrW+1)'(req_i.tag) * (2*AddrW+1)'(RecipM);
  // remainder from the latched tag and quotient, used during StRead
  assign set_calc = tag_q[SetW-1:0] - (quo_lo_q * SetMul);

  for (genvar g = 0; g < Ways; g++) begin : g_way
    sacl_ram #(.Width(AddrW), .Depth(NumSets), .AddrBits(SetW)) u_tag (
      .clk_i  (clk_i),
      .we_i   (we[g]),
      .waddr_i(set_q),
      .wdata_i(tag_q),
      .raddr_i(set_calc),
      .rdata_o(rd_tag[g])
    );
  end

  // compare and victim choice
  logic            hit;
  logic [WayW-1:0] hway, vway, sel;
  always_comb begin
    hit = 1'b0;
    hway = '0;
    vway = '0;
    for (int k = Ways - 1; k >= 0; k--) begin
      if (vld_q[set_q][k] && rd_tag[k] == tag_q) begin
        hit  = 1'b1;
        hway = WayW'(k);
      end
    end
    for (int k = Ways - 1; k >= 0; k--) begin
      if (rank_q[set_q][k] == '0) begin
        vway = WayW'(k);
      end
    end
    for (int k = Ways - 1; k >= 0; k--) begin
      if (!vld_q[set_q][k]) begin
        vway = WayW'(k);
      end
    end
    sel = hit ? hway : vway;
  end

  always_comb begin
    we = '0;
    if (st_q == StUpd && !hit) begin
      we[sel] = 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (!empty_i) st_d = StRead;
      StRead: st_d = StUpd;
      StUpd:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign pop_o  = (st_q == StIdle) && !empty_i;
  assign idle_o = (st_q == StIdle) && empty_i;

  // request capture, then set index while the tag RAMs are read
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tag_q    <= req_i.tag;
      quo_lo_q <= quo_prod[RecipSh +: SetW];
    end
    if (st_q == StRead) begin
      set_q <= set_calc;
    end
  end

  // state, recency, valid and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      hits_q  <= '0;
      miss_q  <= '0;
      valid_o <= 1'b0;
      hit_o   <= 1'b0;
      way_o   <= '0;
      for (int s = 0; s < NumSets; s++) begin
        vld_q[s] <= '0;
        for (int w = 0; w < Ways; w++) begin
          rank_q[s][w] <= WayW'(w);
        end
      end
    end else begin
      st_q    <= st_d;
      valid_o <= 1'b0;
      if (st_q == StUpd) begin
        valid_o <= 1'b1;
        hit_o   <= hit;
        way_o   <= WayOutW'(sel);
        if (hit) begin
          if (hits_q != '1) hits_q <= hits_q + 1'b1;
        end else begin
          if (miss_q != '1) miss_q <= miss_q + 1'b1;
          vld_q[set_q][sel] <= 1'b1;
        end
        for (int w = 0; w < Ways; w++) begin
          if (rank_q[set_q][w] > rank_q[set_q][sel]) begin
            rank_q[set_q][w] <= rank_q[set_q][w] - 1'b1;
          end
        end
        rank_q[set_q][sel] <= WayW'(Ways - 1);
      end
    end
  end

  assign hit_total_o  = hits_q;
  assign miss_total_o = miss_q;
endmodule
`default_nettype wire

>>> rtl/core/set_assoc_cache_lru_lookup.sv
// Set-associative cache tag store with LRU replacement, one result per
// request. The back part steps through its idle, read and update states
// for each request (queue pop with set quotient, set index and tag RAM
// read, compare and update), and result_valid_o is registered from the
// update state. It pops no new request until it is back in idle. A
// two-entry queue sits in front; busy is high while it is full. The
// receiver cannot stall: result_valid_o is high for exactly one cycle.
// cfg_ready_o is always high; write the offset only with no request in flight.
// Depends on sacl_pkg, sacl_front, sacl_back, sacl_ram.
`default_nettype none
module set_assoc_cache_lru_lookup #(
  parameter int unsigned NUM_SETS = 16,
  parameter int unsigned WAYS     = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [sacl_pkg::AddrW-1:0] address_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [sacl_pkg::OffW-1:0]  cfg_data_i,
  output logic                            result_valid_o,
  output logic [sacl_pkg::WayOutW-1:0]    way_o,
  output logic                            hit_o,
  output logic [sacl_pkg::CntW-1:0]       hit_total_o,
  output logic [sacl_pkg::CntW-1:0]       miss_total_o
);
  import sacl_pkg::*;

  logic [OffW-1:0] off_q;
  logic full, empty, pop, idle;
  sacl_req_t req;

  assign busy        = full;
  assign cfg_ready_o = 1'b1;

  // offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      off_q <= cfg_data_i;
    end
  end

  sacl_front #(.QDepth(2)) u_front (
    .clk_i, .rst_ni,
    .push_i(start && !busy), .address_i, .offset_bits_i(off_q),
    .full_o(full), .pop_i(pop), .empty_o(empty), .req_o(req)
  );

  sacl_back #(.NumSets(NUM_SETS), .Ways(WAYS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .req_i(req), .pop_o(pop),
    .idle_o(idle), .valid_o(result_valid_o), .way_o, .hit_o,
    .hit_total_o, .miss_total_o
  );

  // checks
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && hit_o |-> miss_total_o == $past(miss_total_o))
    else $error("miss count moved on hit");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |=> !result_valid_o) else $error("result while idle");
endmodule
`default_nettype wire
